[src/gcc_pkg.sv]
// ---------------------------------------------------------------------------
// gcc_pkg
// Shared types, widths and constants of the grid coast cell counter.
// ---------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

  localparam int CHAR_W = 8;
  localparam int COUNT_W = 21;
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam int DEFAULT_MAX_COLS = 1024;
  localparam int DEFAULT_MAX_ROWS = 1024;
  localparam logic [CFG_W-1:0] CFG_RESET_COUNT = CFG_W'(1024);

  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_DOT = 8'd46;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_index_t;

  // one line store entry: land bit two rows up and one row up
  typedef struct packed {
    logic upper;
    logic middle;
  } line_entry_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int clamp_count(logic [CFG_W-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/gcc_cell_if.sv]
// ---------------------------------------------------------------------------
// gcc_cell_if
// Valid/ready channel carrying one raw grid cell character.
// ---------------------------------------------------------------------------
`default_nettype none

interface gcc_cell_if;
  import gcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink (input valid, input cell_char, output ready);
endinterface

`default_nettype wire

[src/gcc_count_if.sv]
// ---------------------------------------------------------------------------
// gcc_count_if
// Valid/ready channel carrying the coast count of one grid.
// ---------------------------------------------------------------------------
`default_nettype none

interface gcc_count_if;
  import gcc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] coast_count;

  modport source (output valid, output coast_count, input ready);
  modport sink (input valid, input coast_count, output ready);
endinterface

`default_nettype wire

[src/grid_coast_cell_counter.sv]
// ---------------------------------------------------------------------------
// grid_coast_cell_counter
// Counts coast cells of a character grid streamed in raster order.
// ---------------------------------------------------------------------------
// One cell is taken per clock unless the input stalls. Each cell reads its
// column of a 2-bit line store (land bits of the two rows above) in the cycle
// after its transfer, then updates the count and writes the column back; the
// coast count of a grid is loaded into the output register as its last cell
// is processed. The input stalls only while a finished count still waits in
// the output register and the next grid end is about to be loaded. A register
// write restarts the grid. The line store has no reset and needs no clearing.
`default_nettype none

module grid_coast_cell_counter #(
  parameter int MAX_COLS = gcc_pkg::DEFAULT_MAX_COLS,
  parameter int MAX_ROWS = gcc_pkg::DEFAULT_MAX_ROWS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [gcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gcc_pkg::CFG_W-1:0]  cfg_data,
  gcc_cell_if.sink                        cells,
  gcc_count_if.source                     totals
);
  import gcc_pkg::*;

  localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_POS_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

  // configuration
  logic [ROW_CNT_W-1:0] row_count;
  logic [COL_CNT_W-1:0] col_count;

  // position of the next cell
  logic [ROW_POS_W-1:0] row_pos;
  logic [COL_IDX_W-1:0] col_pos;

  // read stage: cell transferred, line store read in flight
  logic                 s1_valid;
  logic                 s1_land;
  logic [COL_IDX_W-1:0] s1_col;
  logic                 s1_first_col;
  logic                 s1_last_col;
  logic                 s1_edge_row;
  logic                 s1_deep;
  logic                 s1_last;
  logic                 fwd;
  line_entry_t          fwd_data;

  // line store
  line_entry_t          line_mem [MAX_COLS];
  line_entry_t          rd_data;

  // update stage state
  logic                 left_land;
  logic                 pend_valid;
  logic                 pend_left;
  logic                 pend_up;
  logic                 pend_below;
  logic [COUNT_W-1:0]   total;

  // output register
  logic                 out_valid;
  logic [COUNT_W-1:0]   out_count;

  logic                 in_fire;
  logic                 stall;
  logic                 proc;
  logic                 land;
  logic                 last_col;
  logic                 last_row;
  logic                 edge_row;
  line_entry_t          ent;
  line_entry_t          wdata;
  logic                 pend_add;
  logic                 cur_valid;
  logic                 cur_left;
  logic                 cur_add;
  logic                 edge_add;
  logic [1:0]           add;
  logic [COUNT_W:0]     sum;
  logic [COUNT_W-1:0]   total_next;

  // a grid end cannot move on while the previous count is still waiting
  assign stall   = s1_valid && s1_last && out_valid && !totals.ready;
  assign proc    = s1_valid && !stall;
  assign in_fire = cells.valid && cells.ready;

  assign cells.ready        = !stall;
  assign totals.valid       = out_valid;
  assign totals.coast_count = out_count;

  assign land     = (cells.cell_char != CHAR_NUL) && (cells.cell_char != CHAR_DOT);
  assign last_col = (int'(col_pos) + 1) >= int'(col_count);
  assign last_row = (int'(row_pos) + 1) >= int'(row_count);
  assign edge_row = (row_pos == '0) || ((int'(row_pos) + 1) == int'(row_count));

  // update stage
  assign ent   = fwd ? fwd_data : rd_data;
  assign wdata = '{upper: ent.middle, middle: s1_land};

  // the pending cell one column left sees its right neighbor now
  assign pend_add  = !s1_first_col && pend_valid &&
                     (!pend_left || !ent.middle || !pend_up || !pend_below);
  assign cur_valid = s1_deep && ent.middle;
  assign cur_left  = s1_first_col ? 1'b0 : left_land;
  // on the last column the right neighbor is outside the grid
  assign cur_add   = s1_last_col && cur_valid;
  assign edge_add  = s1_edge_row && s1_land;

  assign add = 2'(pend_add) + 2'(cur_add) + 2'(edge_add);
  assign sum = {1'b0, total} + (COUNT_W + 1)'(add);
  assign total_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= line_mem[col_pos];
    end
    if (proc) begin
      line_mem[s1_col] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_CNT_W'(clamp_count(CFG_RESET_COUNT, MAX_ROWS));
      col_count <= COL_CNT_W'(clamp_count(CFG_RESET_COUNT, MAX_COLS));
      row_pos   <= '0;
      col_pos   <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ROW_COUNT: row_count <= ROW_CNT_W'(clamp_count(cfg_data, MAX_ROWS));
        REG_COL_COUNT: col_count <= COL_CNT_W'(clamp_count(cfg_data, MAX_COLS));
        default: ;
      endcase
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : ROW_POS_W'(int'(row_pos) + 1);
      end else begin
        col_pos <= COL_IDX_W'(int'(col_pos) + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else if (!stall) begin
      s1_valid <= in_fire;
      // single-column grid: the entry being written is read again at once
      fwd      <= in_fire && proc && (s1_col == col_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      fwd_data     <= wdata;
      s1_land      <= land;
      s1_col       <= col_pos;
      s1_first_col <= (col_pos == '0);
      s1_last_col  <= last_col;
      s1_edge_row  <= edge_row;
      s1_deep      <= (int'(row_pos) >= 2);
      s1_last      <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      pend_valid <= 1'b0;
      left_land  <= 1'b0;
    end else if (cfg_we) begin
      total      <= '0;
      pend_valid <= 1'b0;
    end else if (proc) begin
      total      <= s1_last ? '0 : total_next;
      left_land  <= ent.middle;
      pend_valid <= cur_valid && !s1_last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      pend_left  <= cur_left;
      pend_up    <= ent.upper;
      pend_below <= s1_land;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && s1_last) begin
      out_valid <= 1'b1;
    end else if (totals.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_last) begin
      out_count <= total_next;
    end
  end

  // forwarding is only needed when a row is one column wide
  a_fwd_single_col: assert property (@(posedge clk) disable iff (rst)
    s1_valid && fwd |-> int'(col_count) == 1)
    else $error("line store forward outside a single-column grid");

  // the column position never leaves the configured row width
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(col_pos) < int'(col_count))
    else $error("column position beyond column count");

  // the input is only held back by a waiting count
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> totals.valid && !totals.ready && s1_valid && s1_last)
    else $error("input stalled without a waiting count");

  // a grid end always presents a count in the next cycle
  a_grid_end_out: assert property (@(posedge clk) disable iff (rst)
    proc && s1_last && !cfg_we |=> totals.valid)
    else $error("grid end did not load the output register");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for grid_coast_cell_counter. A short directed plan
// covers one-cell grids, water characters, clamped sizes and a restart in
// the middle of a grid. Random grids of many shapes follow, two of them at
// the full row and column limits. Each total is checked against a pinned
// count or a line-store tracker kept inside the bench.
// ---------------------------------------------------------------------------

module tb;
  import gcc_pkg::*;

  localparam int LIMIT_ROWS = DEFAULT_MAX_ROWS;
  localparam int LIMIT_COLS = DEFAULT_MAX_COLS;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT = 21;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_CELLS = 1850;
  localparam int MIN_GRIDS = 48;

  typedef enum bit {
    STEP_CELL,
    STEP_WRITE
  } step_kind_t;

  typedef struct {
    step_kind_t        kind;
    reg_index_t        idx;
    logic [CFG_W-1:0]  value;
    logic [CHAR_W-1:0] ch;
    bit                pinned;
    logic [COUNT_W-1:0] count;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gcc_cell_if  cells();
  gcc_count_if totals();

  grid_coast_cell_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells),
    .totals    (totals)
  );

  // tracker state: land bits of the two rows above the arriving row
  bit up_line [LIMIT_COLS];
  bit mid_line [LIMIT_COLS];
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned n_rows;
  int unsigned n_cols;
  logic [COUNT_W-1:0] coast_total;
  bit left_land;

  logic [COUNT_W-1:0] pending_counts[$];
  plan_row_t plan[$];
  int errors;
  int grids_done;
  int random_cells;
  logic burst_mode;
  logic hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic bit coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned grid_size(input logic [CFG_W-1:0] raw, input int limit);
    int unsigned v;
    v = raw;
    if (v == 0) begin
      v = 1;
    end else if (v > limit) begin
      v = limit;
    end
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    if (coin(35)) begin
      return coin(50) ? CHAR_NUL : CHAR_DOT;
    end
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic void restart_grid();
    row_pos = 0;
    col_pos = 0;
    coast_total = '0;
    left_land = 1'b0;
  endfunction

  function automatic void bump_total();
    if (coast_total != COUNT_MAX) begin
      coast_total = coast_total + 1'b1;
    end
  endfunction

  function automatic void apply_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
    if (idx == REG_ROW_COUNT) begin
      n_rows = grid_size(value, LIMIT_ROWS);
    end else begin
      n_cols = grid_size(value, LIMIT_COLS);
    end
    restart_grid();
  endfunction

  // an interior cell is decided when the cell below it arrives
  function automatic void track_cell(input logic [CHAR_W-1:0] ch, output bit done,
                                     output logic [COUNT_W-1:0] total);
    bit land;
    bit centre;
    bit right_land;
    bit lft;
    int unsigned r;
    int unsigned c;
    land = (ch != CHAR_NUL) && (ch != CHAR_DOT);
    r = row_pos;
    c = col_pos;
    done = 1'b0;
    total = '0;
    if ((r == 0 || r + 1 == n_rows) && land) begin
      bump_total();
    end
    centre = mid_line[c];
    right_land = (c + 1 < n_cols) ? mid_line[c + 1] : 1'b0;
    if (r >= 2 && centre) begin
      lft = (c > 0) ? left_land : 1'b0;
      if (!lft || !right_land || !up_line[c] || !land) begin
        bump_total();
      end
    end
    left_land = centre;
    up_line[c] = centre;
    mid_line[c] = land;
    if (c + 1 >= n_cols) begin
      col_pos = 0;
      if (r + 1 >= n_rows) begin
        done = 1'b1;
        total = coast_total;
        grids_done++;
        restart_grid();
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic send_cell(input logic [CHAR_W-1:0] ch, input bit pinned,
                           input logic [COUNT_W-1:0] pinned_count);
    bit done;
    logic [COUNT_W-1:0] total;
    while (!burst_mode && coin(IDLE_PCT)) begin
      cells.valid <= 1'b0;
      @(posedge clk);
    end
    cells.valid <= 1'b1;
    cells.cell_char <= ch;
    do @(posedge clk); while (!cells.ready);
    track_cell(ch, done, total);
    if (done) begin
      pending_counts.push_back(pinned ? pinned_count : total);
    end
  endtask

  task automatic await_counts();
    cells.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // a partial grid leaves the block busy with no count to wait for
  task automatic settle();
    await_counts();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    apply_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_write(input reg_index_t idx, input logic [CFG_W-1:0] value);
    plan_row_t p;
    p = '{STEP_WRITE, idx, value, CHAR_NUL, 1'b0, '0};
    plan.push_back(p);
  endtask

  task automatic add_cell(input logic [CHAR_W-1:0] ch, input bit pinned,
                          input logic [COUNT_W-1:0] count);
    plan_row_t p;
    p = '{STEP_CELL, REG_ROW_COUNT, '0, ch, pinned, count};
    plan.push_back(p);
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    logic [COUNT_W-1:0] want;
    hold_left = 0;
    hold_done = 1'b0;
    totals.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && totals.valid && totals.ready) begin
        if (pending_counts.size() == 0) begin
          $display("%0t coast count: expected none, actual %0d", $time, totals.coast_count);
          errors++;
        end else begin
          want = pending_counts.pop_front();
          if (totals.coast_count !== want) begin
            $display("%0t coast count: expected %0d, actual %0d", $time, want,
                     totals.coast_count);
            errors++;
          end
        end
      end
      if (hold_req === 1'b1 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        totals.ready <= 1'b0;
      end else if (burst_mode === 1'b1) begin
        totals.ready <= 1'b1;
      end else begin
        totals.ready <= !coin(IDLE_PCT);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] raw_rows;
    logic [CFG_W-1:0] raw_cols;
    int unsigned grid_cells;
    int n_grids;
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cells.valid = 1'b0;
    cells.cell_char = '0;
    burst_mode = 1'b0;
    hold_req = 1'b0;
    errors = 0;
    grids_done = 0;
    random_cells = 0;
    n_rows = grid_size(CFG_RESET_COUNT, LIMIT_ROWS);
    n_cols = grid_size(CFG_RESET_COUNT, LIMIT_COLS);
    restart_grid();

    // cells under the reset size are dropped by the first write
    add_cell("A", 1'b0, '0);
    add_cell(CHAR_DOT, 1'b0, '0);
    add_cell(CHAR_NUL, 1'b0, '0);
    // one-cell grids: land counts once, water never
    add_write(REG_ROW_COUNT, 11'd1);
    add_write(REG_COL_COUNT, 11'd1);
    add_cell("A", 1'b1, 21'd1);
    add_cell(CHAR_DOT, 1'b1, 21'd0);
    add_cell(CHAR_NUL, 1'b1, 21'd0);
    add_cell(8'hFF, 1'b1, 21'd1);
    add_cell(8'h2D, 1'b1, 21'd1);
    add_cell(8'h2F, 1'b1, 21'd1);
    // zero sizes act as one
    add_write(REG_ROW_COUNT, 11'd0);
    add_write(REG_COL_COUNT, 11'd0);
    add_cell("x", 1'b1, 21'd1);
    // all-land 3x3: the center is enclosed
    add_write(REG_ROW_COUNT, 11'd3);
    add_write(REG_COL_COUNT, 11'd3);
    repeat (9) add_cell("#", 1'b0, '0);
    // restart in the middle of a 2x2 grid
    add_write(REG_ROW_COUNT, 11'd2);
    add_write(REG_COL_COUNT, 11'd2);
    add_cell("a", 1'b0, '0);
    add_cell("b", 1'b0, '0);
    add_write(REG_COL_COUNT, 11'd2);
    add_cell("#", 1'b0, '0);
    add_cell(CHAR_DOT, 1'b0, '0);
    add_cell("#", 1'b0, '0);
    add_cell("#", 1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_cell(plan[i].ch, plan[i].pinned, plan[i].count);
      end
    end

    phase = 0;
    while (random_cells < RANDOM_CELLS || grids_done < MIN_GRIDS) begin
      case (phase)
        1: begin
          raw_rows = 11'd2047;
          raw_cols = 11'd1;
        end
        3: begin
          raw_rows = 11'd1;
          raw_cols = 11'd2047;
        end
        5: begin
          raw_rows = 11'd0;
          raw_cols = 11'd1;
        end
        default: begin
          if (coin(12)) begin
            raw_rows = CFG_W'($urandom_range(0, 40));
            raw_cols = CFG_W'($urandom_range(0, 40));
          end else begin
            raw_rows = CFG_W'($urandom_range(0, 10));
            raw_cols = CFG_W'($urandom_range(0, 12));
          end
        end
      endcase
      settle();
      if (coin(50)) begin
        write_reg(REG_ROW_COUNT, raw_rows);
        write_reg(REG_COL_COUNT, raw_cols);
      end else begin
        write_reg(REG_COL_COUNT, raw_cols);
        write_reg(REG_ROW_COUNT, raw_rows);
      end
      grid_cells = n_rows * n_cols;
      // the tall grid runs with no idling on either side
      burst_mode <= (phase == 1);
      // single-cell grids with the result side held off: the input must stall
      if (phase == 5) begin
        hold_req <= 1'b1;
        n_grids = 40;
      end else if (phase == 1 || phase == 3) begin
        n_grids = 1;
      end else begin
        n_grids = $urandom_range(1, 4);
      end
      for (int g = 0; g < n_grids; g++) begin
        for (int unsigned k = 0; k < grid_cells; k++) begin
          send_cell(random_char(), 1'b0, '0);
          random_cells++;
        end
        if (g == 0 && coin(15)) begin
          await_counts();
        end
      end
      // leave a grid unfinished for the next write to drop
      if (grid_cells > 1 && coin(25)) begin
        repeat ($urandom_range(1, grid_cells - 1)) begin
          send_cell(random_char(), 1'b0, '0);
          random_cells++;
        end
      end
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/gcc_pkg.sv
src/gcc_cell_if.sv
src/gcc_count_if.sv
src/grid_coast_cell_counter.sv
test/tb.sv
